>>> rtl/pdq_pkg.sv
// ----------------------------------------------------------------------------
// pdq_pkg
// Types and constants shared by the pickup/dropout delay qualifier.
// ----------------------------------------------------------------------------
package pdq_pkg;

  localparam int CMD_W       = 2;
  localparam int DELAY_W     = 32;
  localparam int NOW_W       = 32;
  localparam int CFG_INDEX_W = 1;

  localparam logic [DELAY_W-1:0] DELAY_RESET = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_ENABLE = 2'd1,
    CMD_RESET  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PICKUP  = 1'd0,
    REG_DROPOUT = 1'd1
  } reg_index_t;

  typedef struct packed {
    cmd_e_t             cmd;
    logic               level;
    logic               enable_value;
    logic [NOW_W-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] pickup_delay_ms;
    logic [DELAY_W-1:0] dropout_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic enabled;
    logic out_status;
  } status_t;

endpackage

>>> rtl/pdq_if.sv
// ----------------------------------------------------------------------------
// pdq_in_if / pdq_out_if
// Valid/ready channels carrying input items and qualified results.
// ----------------------------------------------------------------------------
interface pdq_in_if import pdq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic               level;
  logic               enable_value;
  logic [NOW_W-1:0]   now_ms;

  modport source (output valid, cmd, level, enable_value, now_ms, input ready);
  modport sink   (input valid, cmd, level, enable_value, now_ms, output ready);
endinterface

interface pdq_out_if;
  logic valid;
  logic ready;
  logic qualified;

  modport source (output valid, qualified, input ready);
  modport sink   (input valid, qualified, output ready);
endinterface

>>> rtl/pdq_core.sv
// ----------------------------------------------------------------------------
// pdq_core
// Timer state and the combinational update applied for one transaction.
// ----------------------------------------------------------------------------
module pdq_core import pdq_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    step,
  input  cfg_t    cfg,
  output logic    qualified_next,
  output status_t status
);

  localparam int CMP_W = (COUNT_WIDTH > DELAY_W) ? COUNT_WIDTH : DELAY_W;

  logic                   enabled, enabled_next;
  logic                   out_status, out_status_next;
  logic                   rise_pending, rise_pending_next;
  logic                   fall_pending, fall_pending_next;
  logic [COUNT_WIDTH-1:0] rise_stamp, rise_stamp_next;
  logic [COUNT_WIDTH-1:0] fall_stamp, fall_stamp_next;

  logic [CMP_W-1:0]       now_ext;
  logic [COUNT_WIDTH-1:0] now_c;
  logic [COUNT_WIDTH-1:0] rise_delta, fall_delta;
  logic                   rise_exceeds, fall_exceeds;

  assign now_ext      = CMP_W'(item.now_ms);
  assign now_c        = now_ext[COUNT_WIDTH-1:0];
  assign rise_delta   = now_c - rise_stamp;
  assign fall_delta   = now_c - fall_stamp;
  assign rise_exceeds = CMP_W'(rise_delta) > CMP_W'(cfg.pickup_delay_ms);
  assign fall_exceeds = CMP_W'(fall_delta) > CMP_W'(cfg.dropout_delay_ms);

  always_comb begin
    enabled_next      = enabled;
    out_status_next   = out_status;
    rise_pending_next = rise_pending;
    fall_pending_next = fall_pending;
    rise_stamp_next   = rise_stamp;
    fall_stamp_next   = fall_stamp;
    unique case (item.cmd)
      CMD_SAMPLE: begin
        if (!enabled) begin
          out_status_next = 1'b0;
        end else if (out_status) begin
          if (item.level) begin
            fall_pending_next = 1'b0;
          end else if (fall_pending) begin
            if (fall_exceeds) begin
              out_status_next   = 1'b0;
              fall_pending_next = 1'b0;
              rise_pending_next = 1'b0;
            end
          end else begin
            fall_stamp_next   = now_c;
            fall_pending_next = 1'b1;
          end
        end else begin
          if (!item.level) begin
            rise_pending_next = 1'b0;
          end else if (rise_pending) begin
            if (rise_exceeds) begin
              out_status_next   = 1'b1;
              fall_pending_next = 1'b0;
              rise_pending_next = 1'b0;
            end
          end else begin
            rise_stamp_next   = now_c;
            rise_pending_next = 1'b1;
          end
        end
      end
      CMD_ENABLE: begin
        out_status_next = 1'b0;
        if (item.enable_value && !enabled) begin
          rise_stamp_next = now_c;
        end
        enabled_next = item.enable_value;
      end
      CMD_RESET: begin
        enabled_next    = 1'b0;
        out_status_next = 1'b0;
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      out_status   <= 1'b0;
      rise_pending <= 1'b0;
      fall_pending <= 1'b0;
      rise_stamp   <= '0;
      fall_stamp   <= '0;
    end else if (step) begin
      enabled      <= enabled_next;
      out_status   <= out_status_next;
      rise_pending <= rise_pending_next;
      fall_pending <= fall_pending_next;
      rise_stamp   <= rise_stamp_next;
      fall_stamp   <= fall_stamp_next;
    end
  end

  assign qualified_next    = out_status_next;
  assign status.enabled    = enabled;
  assign status.out_status = out_status;

endmodule

>>> rtl/pickup_dropout_delay_qualifier.sv
// ----------------------------------------------------------------------------
// pickup_dropout_delay_qualifier
// Asymmetric pickup/dropout qualifier for a sampled binary signal.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the output side is
// ready, returning one result per transaction from the result register. An
// input register feeds one timer update (a COUNT_WIDTH-bit wrapping subtract
// and a compare against the programmed delay), and the new state is written
// back in the same cycle the result register loads, so the next transaction
// sees it without a gap. While a finished result waits to be taken, the input
// register still accepts one more transaction; after that the input stalls
// until the result is taken. Delay registers must only be written while no
// transaction is in flight.
module pickup_dropout_delay_qualifier import pdq_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  pdq_in_if.sink                 in_ch,
  pdq_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]     cfg_data
);

  cfg_t    cfg;
  status_t status;
  logic    s_valid;
  item_t   s_item;
  logic    advance;
  logic    qualified_next;
  logic    out_valid;
  logic    out_qualified;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pickup_delay_ms  <= DELAY_RESET;
      cfg.dropout_delay_ms <= DELAY_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PICKUP:  cfg.pickup_delay_ms  <= cfg_data;
        REG_DROPOUT: cfg.dropout_delay_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign advance     = s_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_item.cmd          <= cmd_e_t'(in_ch.cmd);
      s_item.level        <= in_ch.level;
      s_item.enable_value <= in_ch.enable_value;
      s_item.now_ms       <= in_ch.now_ms;
    end
  end

  pdq_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .item           (s_item),
    .step           (advance),
    .cfg            (cfg),
    .qualified_next (qualified_next),
    .status         (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_qualified <= qualified_next;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.qualified = out_qualified;

  a_status_needs_enable : assert property (@(posedge clk) disable iff (rst)
    status.out_status |-> status.enabled)
    else $error("qualified status set while disabled");

  a_result_matches_state : assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_qualified == status.out_status) && out_valid)
    else $error("result register does not match timer state");

  a_control_clears_output : assert property (@(posedge clk) disable iff (rst)
    advance && (s_item.cmd == CMD_ENABLE || s_item.cmd == CMD_RESET)
      |=> !out_qualified)
    else $error("enable or reset transaction left the output set");

endmodule
